// ----- rtl/fpm_pkg.sv -----
// ============================================================================
// fpm_pkg
// Shared types, constants and the microcode table of the page map builder.
// ============================================================================
package fpm_pkg;

    localparam int POOL_PAGES       = 64;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int STORE_DEPTH      = POOL_PAGES * ENTRIES_PER_PAGE;
    localparam int STORE_AW         = $clog2(STORE_DEPTH);
    localparam int PAGE_W           = $clog2(POOL_PAGES);
    localparam int PU_W             = $clog2(POOL_PAGES + 1);
    localparam int IDX_W            = $clog2(ENTRIES_PER_PAGE);
    localparam int ENTRY_W          = 64;
    localparam int BASE_W           = 40;
    localparam int VA_W             = 48;
    localparam int PA_W             = 52;
    localparam int OFFSET_W         = 12;
    localparam int HI_W             = ENTRY_W - OFFSET_W;
    localparam int STEP_W           = 4;

    localparam logic [ENTRY_W-1:0] ENTRY_FLAGS = ENTRY_W'(3);
    localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(10);

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_READ,
        UOP_SUB,
        UOP_FOLLOW,
        UOP_LINK,
        UOP_LEAF,
        UOP_FAIL,
        UOP_DONE
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_MISALIGNED,
        COND_LAST_LEVEL,
        COND_ENTRY_ZERO,
        COND_BAD_LINK,
        COND_POOL_FULL
    } cond_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_MISALIGNED,
        STATUS_POOL_EMPTY,
        STATUS_BAD_LINK
    } status_t;

    typedef struct packed {
        uop_t    uop;
        cond_t   cond;
        step_t   target;
        status_t fail_code;
    } ucode_t;

    typedef struct packed {
        uop_t    uop;
        status_t fail_code;
    } dp_ctrl_t;

    typedef struct packed {
        logic misaligned;
        logic last_level;
        logic entry_zero;
        logic bad_link;
        logic pool_full;
    } dp_flags_t;

    localparam step_t STEP_ALIGN      = step_t'(0);
    localparam step_t STEP_LEVEL      = step_t'(1);
    localparam step_t STEP_READ       = step_t'(2);
    localparam step_t STEP_EVAL       = step_t'(3);
    localparam step_t STEP_CHECK      = step_t'(4);
    localparam step_t STEP_FOLLOW     = step_t'(5);
    localparam step_t STEP_ALLOC      = step_t'(6);
    localparam step_t STEP_LINK       = step_t'(7);
    localparam step_t STEP_LEAF       = step_t'(8);
    localparam step_t STEP_MISALIGNED = step_t'(9);
    localparam step_t STEP_BAD_LINK   = step_t'(10);
    localparam step_t STEP_POOL_EMPTY = step_t'(11);
    localparam step_t STEP_DONE       = step_t'(12);

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        unique case (step)
            STEP_ALIGN:      word = '{UOP_NOP,    COND_MISALIGNED, STEP_MISALIGNED, STATUS_OK};
            STEP_LEVEL:      word = '{UOP_NOP,    COND_LAST_LEVEL, STEP_LEAF,       STATUS_OK};
            STEP_READ:       word = '{UOP_READ,   COND_NEVER,      STEP_ALIGN,      STATUS_OK};
            STEP_EVAL:       word = '{UOP_SUB,    COND_ENTRY_ZERO, STEP_ALLOC,      STATUS_OK};
            STEP_CHECK:      word = '{UOP_NOP,    COND_BAD_LINK,   STEP_BAD_LINK,   STATUS_OK};
            STEP_FOLLOW:     word = '{UOP_FOLLOW, COND_ALWAYS,     STEP_LEVEL,      STATUS_OK};
            STEP_ALLOC:      word = '{UOP_NOP,    COND_POOL_FULL,  STEP_POOL_EMPTY, STATUS_OK};
            STEP_LINK:       word = '{UOP_LINK,   COND_ALWAYS,     STEP_LEVEL,      STATUS_OK};
            STEP_LEAF:       word = '{UOP_LEAF,   COND_ALWAYS,     STEP_DONE,       STATUS_OK};
            STEP_MISALIGNED: word = '{UOP_FAIL,   COND_ALWAYS,     STEP_DONE,
                                      STATUS_MISALIGNED};
            STEP_BAD_LINK:   word = '{UOP_FAIL,   COND_ALWAYS,     STEP_DONE,
                                      STATUS_BAD_LINK};
            STEP_POOL_EMPTY: word = '{UOP_FAIL,   COND_ALWAYS,     STEP_DONE,
                                      STATUS_POOL_EMPTY};
            STEP_DONE:       word = '{UOP_DONE,   COND_NEVER,      STEP_ALIGN,      STATUS_OK};
            default:         word = '{UOP_DONE,   COND_NEVER,      STEP_ALIGN,      STATUS_OK};
        endcase
        return word;
    endfunction

endpackage

// ----- rtl/fpm_ram.sv -----
// ============================================================================
// fpm_ram
// Generic single-port RAM with registered read.
// ============================================================================
module fpm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fpm_sequencer.sv -----
// ============================================================================
// fpm_sequencer
// Step counter and microcode table with conditional jumps.
// ============================================================================
module fpm_sequencer
    import fpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  dp_flags_t flags,
    output dp_ctrl_t  ctrl,
    output logic      running
);

    logic   run_reg;
    logic   run_next;
    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   taken;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        unique case (word.cond)
            COND_NEVER:      taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_MISALIGNED: taken = flags.misaligned;
            COND_LAST_LEVEL: taken = flags.last_level;
            COND_ENTRY_ZERO: taken = flags.entry_zero;
            COND_BAD_LINK:   taken = flags.bad_link;
            COND_POOL_FULL:  taken = flags.pool_full;
            default:         taken = 1'b0;
        endcase
    end

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        if (go)
        begin
            run_next  = 1'b1;
            step_next = STEP_ALIGN;
        end
        else if (run_reg)
        begin
            if (word.uop == UOP_DONE)
            begin
                run_next = 1'b0;
            end
            step_next = taken ? word.target : step_t'(step_reg + step_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= STEP_ALIGN;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    assign ctrl.uop       = run_reg ? word.uop : UOP_NOP;
    assign ctrl.fail_code = word.fail_code;
    assign running        = run_reg;

endmodule

// ----- rtl/fpm_datapath.sv -----
// ============================================================================
// fpm_datapath
// Walk registers, table store port, allocation counter and result fields.
// ============================================================================
module fpm_datapath
    import fpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [PA_W-1:0]   phys_target,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_wdata,
    input  dp_ctrl_t          ctrl,
    output dp_flags_t         flags,
    output logic              clearing,
    output logic              done,
    output logic [1:0]        status,
    output logic [1:0]        new_tables,
    output logic [PA_W-1:0]   leaf_slot_addr,
    output logic [6:0]        pages_in_use
);

    logic [VA_W-1:0]     va_reg;
    logic [PA_W-1:0]     pa_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [1:0]          level_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [PU_W-1:0]     pages_used_reg;
    logic [1:0]          fresh_reg;
    status_t             status_reg;
    logic [PA_W-1:0]     leaf_reg;
    logic [HI_W:0]       diff_reg;
    logic                done_reg;
    logic                clearing_reg;
    logic [STORE_AW-1:0] clr_addr_reg;

    logic [IDX_W-1:0]    idx;
    logic [PAGE_W-1:0]   new_page;
    logic [BASE_W:0]     link_sum;
    logic [BASE_W:0]     leaf_sum;
    logic                mem_we;
    logic                mem_re;
    logic [STORE_AW-1:0] mem_addr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ENTRY_W-1:0]  mem_rdata;

    // level index from the virtual address
    always_comb
    begin
        unique case (level_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign new_page = pages_used_reg[PAGE_W-1:0];
    assign link_sum = {1'b0, base_reg} + (BASE_W+1)'(new_page);
    assign leaf_sum = {1'b0, base_reg} + (BASE_W+1)'(page_reg);

    assign mem_re = (ctrl.uop == UOP_READ);
    assign mem_we = clearing_reg || (ctrl.uop == UOP_LINK) || (ctrl.uop == UOP_LEAF);

    always_comb
    begin
        priority if (clearing_reg)
        begin
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (ctrl.uop == UOP_LINK)
        begin
            mem_addr  = {page_reg, idx};
            mem_wdata = ENTRY_W'({link_sum, OFFSET_W'(0)}) | ENTRY_FLAGS;
        end
        else
        begin
            mem_addr  = {page_reg, idx};
            mem_wdata = ENTRY_W'(pa_reg) | ENTRY_FLAGS;
        end
    end

    fpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign flags.misaligned = (va_reg[OFFSET_W-1:0] != '0) || (pa_reg[OFFSET_W-1:0] != '0);
    assign flags.last_level = (level_reg == 2'd3);
    assign flags.entry_zero = (mem_rdata == '0);
    assign flags.bad_link   = diff_reg[HI_W] || (diff_reg[HI_W-1:0] >= HI_W'(pages_used_reg));
    assign flags.pool_full  = (pages_used_reg >= PU_W'(POOL_PAGES));

    // store clear after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + STORE_AW'(1);
            if (clr_addr_reg == STORE_AW'(STORE_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= BASE_RESET;
            pages_used_reg <= PU_W'(1);
            done_reg       <= 1'b0;
            level_reg      <= '0;
            page_reg       <= '0;
            fresh_reg      <= '0;
            status_reg     <= STATUS_OK;
            leaf_reg       <= '0;
        end
        else
        begin
            done_reg <= (ctrl.uop == UOP_DONE);
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (go)
            begin
                level_reg  <= '0;
                page_reg   <= '0;
                fresh_reg  <= '0;
                status_reg <= STATUS_OK;
                leaf_reg   <= '0;
            end
            else
            begin
                unique case (ctrl.uop)
                    UOP_FOLLOW:
                    begin
                        page_reg  <= diff_reg[PAGE_W-1:0];
                        level_reg <= level_reg + 2'd1;
                    end
                    UOP_LINK:
                    begin
                        page_reg       <= new_page;
                        pages_used_reg <= pages_used_reg + PU_W'(1);
                        fresh_reg      <= fresh_reg + 2'd1;
                        level_reg      <= level_reg + 2'd1;
                    end
                    UOP_LEAF:
                    begin
                        leaf_reg <= {leaf_sum[BASE_W-1:0], idx, 3'b000};
                    end
                    UOP_FAIL:
                    begin
                        status_reg <= ctrl.fail_code;
                    end
                    UOP_NOP, UOP_READ, UOP_SUB, UOP_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // request latch at go, and the page number of a linked entry relative to the pool, borrow on top
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            va_reg <= virt_addr;
            pa_reg <= phys_target;
        end
        if (ctrl.uop == UOP_SUB)
        begin
            diff_reg <= {1'b0, mem_rdata[ENTRY_W-1:OFFSET_W]} - (HI_W+1)'(base_reg);
        end
    end

    assign clearing       = clearing_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign new_tables     = fresh_reg;
    assign leaf_slot_addr = leaf_reg;
    assign pages_in_use   = 7'(pages_used_reg);

endmodule

// ----- rtl/four_level_page_map_builder_core.sv -----
// ============================================================================
// four_level_page_map_builder_core
// Installs 4 KiB mappings in a four-level page table held in a table pool.
// ============================================================================
// After reset the block clears all STORE_DEPTH entries of its table store
// (32768 with the default pool), one entry per cycle, and holds busy high
// meanwhile; cfg_we writes of the pool base are taken during that time. A
// transaction is taken when start is high and busy is low. The walk is run by
// a microcode sequencer over one store port with a registered read: it checks
// alignment, at each upper level reads the entry and either follows a valid
// link or allocates and links a fresh page, then writes the leaf; a failed
// check ends the walk early with its status. The result appears for one cycle
// with done high and must be captured then; busy falls in that same cycle.
// ============================================================================
module four_level_page_map_builder_core
    import fpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [PA_W-1:0]   phys_target,
    input  logic              cfg_we,
    input  logic [BASE_W-1:0] cfg_wdata,
    output logic              done,
    output logic [1:0]        status,
    output logic [1:0]        new_tables,
    output logic [PA_W-1:0]   leaf_slot_addr,
    output logic [6:0]        pages_in_use
);

    logic      go;
    logic      running;
    logic      clearing;
    dp_ctrl_t  ctrl;
    dp_flags_t flags;

    assign busy = running || clearing;
    assign go   = start && !busy;

    fpm_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .flags   (flags),
        .ctrl    (ctrl),
        .running (running)
    );

    fpm_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (go),
        .virt_addr      (virt_addr),
        .phys_target    (phys_target),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .ctrl           (ctrl),
        .flags          (flags),
        .clearing       (clearing),
        .done           (done),
        .status         (status),
        .new_tables     (new_tables),
        .leaf_slot_addr (leaf_slot_addr),
        .pages_in_use   (pages_in_use)
    );

endmodule

// ----- dv/fpm_tb_pkg.sv -----
// ============================================================================
// fpm_tb_pkg
// Shadow page table for the page map builder testbench. It mirrors the table
// pool, the allocation counter and the pool base register, works out the
// result of each accepted transaction and compares it with what the block
// returns.
// ============================================================================
package fpm_tb_pkg;

    import fpm_pkg::*;

    typedef struct {
        status_t             status;
        logic [1:0]          new_tables;
        logic [PA_W-1:0]     leaf_slot_addr;
        logic [6:0]          pages_in_use;
    } map_result_t;

    class page_table_shadow;

        bit [ENTRY_W-1:0]  table_mem[STORE_DEPTH];
        int unsigned       pages_taken;
        logic [BASE_W-1:0] pool_base;
        map_result_t       pending_results[$];
        int unsigned       errors;

        function new();
            pages_taken = 1;
            pool_base   = BASE_RESET;
            errors      = 0;
        endfunction

        function void set_base(logic [BASE_W-1:0] value);
            pool_base = value;
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        // walk the four levels and install the leaf
        function void record_mapping(logic [VA_W-1:0] va, logic [PA_W-1:0] pa);
            map_result_t      res;
            int unsigned      page;
            int unsigned      slot;
            int unsigned      fresh_page;
            logic [IDX_W-1:0] idx;
            logic [63:0]      entry;
            logic [63:0]      next_page;
            res.status         = STATUS_OK;
            res.new_tables     = '0;
            res.leaf_slot_addr = '0;
            page               = 0;
            if (va[OFFSET_W-1:0] != '0 || pa[OFFSET_W-1:0] != '0)
            begin
                res.status = STATUS_MISALIGNED;
            end
            else
            begin
                for (int lvl = 0; lvl < 4; lvl++)
                begin
                    idx  = va[OFFSET_W + IDX_W * (3 - lvl) +: IDX_W];
                    slot = page * ENTRIES_PER_PAGE + idx;
                    if (lvl == 3)
                    begin
                        table_mem[slot] = 64'(pa) | ENTRY_FLAGS;
                        res.leaf_slot_addr = PA_W'(((64'(pool_base) + 64'(page)) << OFFSET_W)
                                                   + 64'(idx) * 8);
                        break;
                    end
                    entry = table_mem[slot];
                    if (entry == '0)
                    begin
                        if (pages_taken >= POOL_PAGES)
                        begin
                            res.status = STATUS_POOL_EMPTY;
                            break;
                        end
                        fresh_page = pages_taken;
                        pages_taken++;
                        for (int e = 0; e < ENTRIES_PER_PAGE; e++)
                            table_mem[fresh_page * ENTRIES_PER_PAGE + e] = '0;
                        table_mem[slot] = ((64'(pool_base) + 64'(fresh_page)) << OFFSET_W)
                                          | ENTRY_FLAGS;
                        res.new_tables++;
                        page = fresh_page;
                    end
                    else
                    begin
                        next_page = (entry >> OFFSET_W) - 64'(pool_base);
                        if (next_page >= 64'(pages_taken))
                        begin
                            res.status = STATUS_BAD_LINK;
                            break;
                        end
                        page = int'(next_page);
                    end
                end
            end
            res.pages_in_use = 7'(pages_taken);
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] status, logic [1:0] new_tables,
                                   logic [PA_W-1:0] leaf_slot_addr,
                                   logic [6:0] pages_in_use);
            map_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding: status %0d", status);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (status !== exp_res.status)
            begin
                $error("status: expected %0d, actual %0d", exp_res.status, status);
                errors++;
            end
            if (new_tables !== exp_res.new_tables)
            begin
                $error("new_tables: expected %0d, actual %0d", exp_res.new_tables,
                       new_tables);
                errors++;
            end
            if (leaf_slot_addr !== exp_res.leaf_slot_addr)
            begin
                $error("leaf_slot_addr: expected 0x%0h, actual 0x%0h",
                       exp_res.leaf_slot_addr, leaf_slot_addr);
                errors++;
            end
            if (pages_in_use !== exp_res.pages_in_use)
            begin
                $error("pages_in_use: expected %0d, actual %0d", exp_res.pages_in_use,
                       pages_in_use);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- dv/tb_top.sv -----
// ============================================================================
// tb_top
// Testbench for four_level_page_map_builder_core: directed and random mapping
// requests over several pool base settings, checked against a shadow table.
// ============================================================================
module tb_top;

    import fpm_pkg::*;
    import fpm_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 315;
    localparam int PHASES           = 6;
    localparam int KNOWN_MAX        = 48;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_target;
    logic              cfg_we;
    logic [BASE_W-1:0] cfg_wdata;
    logic              done;
    logic [1:0]        status;
    logic [1:0]        new_tables;
    logic [PA_W-1:0]   leaf_slot_addr;
    logic [6:0]        pages_in_use;

    page_table_shadow  shadow;
    logic [VA_W-1:0]   known_vas[$];
    int unsigned       cycle_count;

    four_level_page_map_builder_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .virt_addr      (virt_addr),
        .phys_target    (phys_target),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .done           (done),
        .status         (status),
        .new_tables     (new_tables),
        .leaf_slot_addr (leaf_slot_addr),
        .pages_in_use   (pages_in_use)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            shadow.check_result(status, new_tables, leaf_slot_addr, pages_in_use);
    end

    task automatic write_base(input logic [BASE_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        shadow.set_base(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (shadow.pending_count() != 0)
            @(negedge clk);
    endtask

    // one transaction, entered and left at a falling edge
    task automatic send_request(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa,
                                input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
        start       = 1'b1;
        virt_addr   = va;
        phys_target = pa;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        shadow.record_mapping(va, pa);
        if (va[OFFSET_W-1:0] == '0)
        begin
            known_vas.push_back(va);
            if (known_vas.size() > KNOWN_MAX)
                known_vas.delete($urandom_range(0, KNOWN_MAX - 1));
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    // mostly walks along known paths with fresh lower levels
    function automatic void make_request(output logic [VA_W-1:0] va,
                                         output logic [PA_W-1:0] pa);
        int                kind;
        int                keep_shift;
        logic [VA_W-1:0]   rnd;
        logic [VA_W-1:0]   upper_mask;
        logic [VA_W-1:0]   kept;
        kind = $urandom_range(0, 99);
        rnd  = VA_W'({$urandom, $urandom});
        pa   = PA_W'({$urandom, $urandom});
        if (kind < 8)
        begin
            va = rnd;
            return;
        end
        case ($urandom_range(0, 9))
            0:       pa = '0;
            1:       pa = '1;
            default: ;
        endcase
        pa[OFFSET_W-1:0] = '0;
        if (kind < 16 || known_vas.size() == 0)
        begin
            va = rnd;
        end
        else
        begin
            kept       = known_vas[$urandom_range(0, known_vas.size() - 1)];
            keep_shift = OFFSET_W + IDX_W * $urandom_range(0, 3);
            upper_mask = '1 << keep_shift;
            va         = (kept & upper_mask) | (rnd & ~upper_mask);
        end
        va[OFFSET_W-1:0] = '0;
    endfunction

    initial
    begin
        logic [BASE_W-1:0] phase_base[PHASES];
        int                phase_idle[PHASES];
        logic [VA_W-1:0]   va;
        logic [PA_W-1:0]   pa;
        shadow      = new();
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        virt_addr   = '0;
        phys_target = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        phase_base  = '{40'd0, 40'd1, '1, 40'd0, BASE_W'($urandom_range(2, 9)), BASE_RESET};
        phase_idle  = '{0, 53, 11, 53, 0, 11};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_base(phase_base[0]);

        // directed: extremes, shared prefixes, remap, misaligned cases
        send_request(48'h0, 52'h0, 0);
        send_request(48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 0);
        send_request(48'h0, 52'h0_0000_1234_5000, 0);
        send_request(48'h0000_0000_1000, 52'h0_0000_0000_1000, 0);
        send_request(48'h0000_0020_0000, 52'h5_5555_5555_5000, 0);
        send_request(48'h0000_4000_0000, 52'hA_AAAA_AAAA_A000, 0);
        send_request(48'h0080_0000_0000, 52'h8_0000_0000_0000, 0);
        send_request(48'h0000_0000_0001, 52'h0, 0);
        send_request(48'h0000_0000_0800, 52'h0, 0);
        send_request(48'h0000_0000_2000, 52'h0_0000_0000_0001, 0);
        send_request(48'h0000_0000_2000, 52'h0_0000_0000_0800, 0);
        send_request(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                write_base(phase_base[ph]);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == RANDOM_PER_PHASE / 2)
                    wait_drained();
                make_request(va, pa);
                send_request(va, pa, phase_idle[ph]);
            end
        end

        wait_drained();
        repeat (30) @(posedge clk);
        if (shadow.errors == 0 && shadow.pending_count() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
